// ===== sv/timer_task_slot_scheduler_defines.svh =====
// Assertion macros used by the checker file
`ifndef TIMER_TASK_SLOT_SCHEDULER_DEFINES_SVH
`define TIMER_TASK_SLOT_SCHEDULER_DEFINES_SVH

// checked outside reset only
`define TTS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/tts_pkg.sv =====
package tts_pkg;

	localparam int NUM_SLOTS_DEF = 8;
	localparam int MAX_RESULTS   = 8;
	localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
	localparam int Q_DEPTH       = 2;

	localparam logic [1:0] FUNC_TICK     = 2'd0;
	localparam logic [1:0] FUNC_ADD_ONCE = 2'd1;
	localparam logic [1:0] FUNC_ADD_PER  = 2'd2;
	localparam logic [1:0] FUNC_REMOVE   = 2'd3;

	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_FIRE   = 2'd2;

	localparam logic [7:0] TPM_RESET = 8'd1;

	// classified request, front to back
	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] arg;
		logic        rm_ok;
	} req_t;

	function automatic logic [3:0] slot_id(input logic [4:0] idx);
		logic [4:0] s;
		s = idx + 5'd1;
		return s[3:0];
	endfunction

endpackage

// ===== sv/timer_task_slot_scheduler.sv =====
// Microsecond time base with NUM_SLOTS task slots. Requests enter a two-entry
// queue and are carried out by an executor that holds the clock, the prescaler
// and the slot table; results leave through an output register, so a tick
// can be taken while a result waits. An add or a remove is carried out and its
// result loaded when the executor takes it. A tick runs a clock update, then a
// parallel due check of all slots, then one firing a cycle from the due mask
// while the output register is free; a quiet tick gives no result.
module timer_task_slot_scheduler #(
	parameter int NUM_SLOTS = tts_pkg::NUM_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,   // ticks_per_microsecond
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,     // argument
	input  logic [1:0]  s_tuser,     // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,     // task_id [3:0], now_us [35:4], zero [39:36]
	output logic [1:0]  m_tuser,     // kind
	output logic        m_tlast
);

	logic [7:0]     tpm_q;
	logic           q_valid, q_pop;
	tts_pkg::req_t  q_req;
	logic [3:0]     out_id;
	logic [31:0]    out_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q <= tts_pkg::TPM_RESET;
		end else if (cfg_we) begin
			tpm_q <= cfg_wdata;
		end
	end

	tts_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_func  (s_tuser),
		.in_arg   (s_tdata),
		.q_valid  (q_valid),
		.q_req    (q_req),
		.q_pop    (q_pop)
	);

	tts_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_tpm   (tpm_q),
		.q_valid   (q_valid),
		.q_req     (q_req),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_id    (out_id),
		.out_now   (out_now),
		.out_last  (m_tlast)
	);

	assign m_tdata = {4'd0, out_now, out_id};

endmodule

// ===== sv/tts_front.sv =====
module tts_front #(
	parameter int NUM_SLOTS = tts_pkg::NUM_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_func,
	input  logic [31:0]       in_arg,
	output logic              q_valid,
	output tts_pkg::req_t     q_req,
	input  logic              q_pop
);

	localparam int PW = (tts_pkg::Q_DEPTH > 1) ? $clog2(tts_pkg::Q_DEPTH) : 1;
	localparam int CW = $clog2(tts_pkg::Q_DEPTH + 1);

	tts_pkg::req_t     mem_q [tts_pkg::Q_DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     cnt_q;
	tts_pkg::req_t     req_in;
	logic              push, pop;

	always_comb begin
		req_in.func  = in_func;
		req_in.arg   = in_arg;
		req_in.rm_ok = (in_arg >= 32'd1) && (in_arg <= 32'(NUM_SLOTS));
	end

	assign in_ready = (cnt_q != CW'(tts_pkg::Q_DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_req    = mem_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= req_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(tts_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(tts_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/tts_back.sv =====
module tts_back #(
	parameter int NUM_SLOTS = tts_pkg::NUM_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        cfg_tpm,
	input  logic              q_valid,
	input  tts_pkg::req_t     q_req,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        out_kind,
	output logic [3:0]        out_id,
	output logic [31:0]       out_now,
	output logic              out_last
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MASK = 2'd1;
	localparam logic [1:0] ST_FIRE = 2'd2;

	logic [1:0]            state_q;
	logic [31:0]           clock_q;
	logic [7:0]            presc_q;
	logic [NUM_SLOTS-1:0]  active_q;
	logic [31:0]           due_q    [NUM_SLOTS];
	logic [31:0]           period_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]  mask_q;
	logic [tts_pkg::CNT_W-1:0] cnt_q;

	logic                  ov_q, olast_q;
	logic [1:0]            okind_q;
	logic [3:0]            oid_q;
	logic [31:0]           onow_q;

	logic                  out_free;
	logic                  out_load;
	logic                  free_found;
	logic [IW-1:0]         free_idx;
	logic [IW-1:0]         sel_idx;
	logic [NUM_SLOTS-1:0]  sel_oh, due_hit, rest;
	logic [7:0]            limit, presc_inc;
	logic                  fire_last;
	logic [IW-1:0]         rm_idx;
	logic                  is_tick, is_add;

	assign out_free = !ov_q || out_ready;
	assign is_tick  = (q_req.func == tts_pkg::FUNC_TICK);
	assign is_add   = (q_req.func == tts_pkg::FUNC_ADD_ONCE) ||
	                  (q_req.func == tts_pkg::FUNC_ADD_PER);
	assign q_pop    = (state_q == ST_IDLE) && q_valid && (is_tick || out_free);
	assign out_load = (q_pop && !is_tick) || ((state_q == ST_FIRE) && out_free);
	assign rm_idx   = IW'(q_req.arg - 32'd1);
	assign limit    = (cfg_tpm == 8'd0) ? 8'd1 : cfg_tpm;
	assign presc_inc = presc_q + 8'd1;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		sel_idx    = '0;
		sel_oh     = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
			if (mask_q[i]) begin
				sel_idx = IW'(i);
				sel_oh  = NUM_SLOTS'(1) << i;
			end
			due_hit[i] = active_q[i] && (due_q[i] <= clock_q);
		end
		rest      = mask_q & ~sel_oh;
		fire_last = (rest == '0) || (cnt_q == tts_pkg::CNT_W'(tts_pkg::MAX_RESULTS - 1));
	end

	// slot payload
	always_ff @(posedge clk) begin
		if (q_pop && is_add && free_found) begin
			if (q_req.func == tts_pkg::FUNC_ADD_ONCE) begin
				due_q[free_idx]    <= q_req.arg;
				period_q[free_idx] <= '0;
			end else begin
				due_q[free_idx]    <= clock_q + q_req.arg;
				period_q[free_idx] <= q_req.arg;
			end
		end else if (state_q == ST_FIRE && out_free && period_q[sel_idx] != '0) begin
			due_q[sel_idx] <= due_q[sel_idx] + period_q[sel_idx];
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (q_pop && !is_tick) begin
			okind_q <= is_add ? tts_pkg::KIND_ADD : tts_pkg::KIND_REMOVE;
			if (is_add) begin
				oid_q <= free_found ? tts_pkg::slot_id(5'(free_idx)) : 4'd0;
			end else begin
				oid_q <= q_req.rm_ok ? q_req.arg[3:0] : 4'd0;
			end
			onow_q  <= clock_q;
			olast_q <= 1'b1;
		end else if (state_q == ST_FIRE && out_free) begin
			okind_q <= tts_pkg::KIND_FIRE;
			oid_q   <= tts_pkg::slot_id(5'(sel_idx));
			onow_q  <= clock_q;
			olast_q <= fire_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			clock_q  <= '0;
			presc_q  <= '0;
			active_q <= '0;
			mask_q   <= '0;
			cnt_q    <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (is_tick) begin
							if (presc_inc >= limit) begin
								presc_q <= '0;
								clock_q <= clock_q + 32'd1;
							end else begin
								presc_q <= presc_inc;
							end
							state_q <= ST_MASK;
						end else begin
							if (is_add && free_found) begin
								active_q[free_idx] <= 1'b1;
							end else if (!is_add && q_req.rm_ok) begin
								active_q[rm_idx] <= 1'b0;
							end
						end
					end
				end
				ST_MASK: begin
					mask_q  <= due_hit;
					cnt_q   <= '0;
					state_q <= (due_hit != '0) ? ST_FIRE : ST_IDLE;
				end
				ST_FIRE: begin
					if (out_free) begin
						mask_q <= rest;
						cnt_q  <= cnt_q + 1'b1;
						if (period_q[sel_idx] == '0) begin
							active_q[sel_idx] <= 1'b0;
						end
						if (fire_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = ov_q;
	assign out_kind  = okind_q;
	assign out_id    = oid_q;
	assign out_now   = onow_q;
	assign out_last  = olast_q;

endmodule

// ===== sv/tts_checker.sv =====
`include "timer_task_slot_scheduler_defines.svh"

module tts_checker #(
	parameter int NUM_SLOTS = tts_pkg::NUM_SLOTS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [7:0]  cfg_wdata,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	`TTS_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")
	`TTS_ASSERT(a_single_last, clk, arst_n, m_tvalid && (m_tuser == tts_pkg::KIND_ADD || m_tuser == tts_pkg::KIND_REMOVE) |-> m_tlast, "add or remove result not last")
	`TTS_ASSERT(a_fire_id, clk, arst_n, m_tvalid && m_tuser == tts_pkg::KIND_FIRE && NUM_SLOTS < 16 |-> m_tdata[3:0] != 4'd0, "firing with slot id zero")
	`TTS_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !m_tvalid, "result valid after reset")

endmodule

bind timer_task_slot_scheduler tts_checker #(.NUM_SLOTS(NUM_SLOTS)) u_checker (.*);

// ===== bench/tb_timer_task_slot_scheduler.sv =====
module tb_timer_task_slot_scheduler;
	timeunit 1ns;
	timeprecision 1ps;

	import tts_pkg::*;

	typedef struct {
		logic [1:0]  func;
		logic [31:0] arg;
	} sched_request_t;

	typedef struct {
		logic [1:0]  kind;
		logic [3:0]  task_id;
		logic [31:0] now_us;
		logic        last;
	} sched_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = 8'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = 32'd0;
	logic [1:0]  s_tuser = FUNC_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	timer_task_slot_scheduler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #6 clk = ~clk;

	// predicted block state
	logic [31:0] tb_now = 32'd0;
	logic [7:0]  tb_prescale = 8'd0;
	logic [7:0]  tb_tpm = TPM_RESET;
	logic        tb_active [NUM_SLOTS_DEF];
	logic [31:0] tb_due [NUM_SLOTS_DEF];
	logic [31:0] tb_period [NUM_SLOTS_DEF];

	// stimulus-side view of the clock, used to place due times near now
	logic [31:0] gen_now = 32'd0;
	logic [7:0]  gen_prescale = 8'd0;
	logic [7:0]  gen_tpm = TPM_RESET;

	sched_request_t pending_requests[$];
	sched_result_t  expected_results[$];
	sched_request_t next_req;
	sched_result_t  want;
	int  fail_count = 0;
	int  src_gap = 0;
	int  snk_gap = 0;
	bit  idle_on = 1'b1;

	initial begin
		for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
			tb_active[i] = 1'b0;
			tb_due[i] = 32'd0;
			tb_period[i] = 32'd0;
		end
	end

	task automatic push_result(input logic [1:0] kind, input int id, input logic last);
		sched_result_t res;
		res.kind = kind;
		res.task_id = 4'(id);
		res.now_us = tb_now;
		res.last = last;
		expected_results.push_back(res);
	endtask

	task automatic run_timer_table(input logic [1:0] func, input logic [31:0] arg);
		logic [7:0] lim;
		int fired[$];
		int slot;
		slot = -1;
		case (func)
		FUNC_TICK: begin
			lim = (tb_tpm == 8'd0) ? 8'd1 : tb_tpm;
			tb_prescale = tb_prescale + 8'd1;
			if (tb_prescale >= lim) begin
				tb_prescale = 8'd0;
				tb_now = tb_now + 32'd1;
			end
			for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
				if (fired.size() < MAX_RESULTS && tb_active[i] && tb_due[i] <= tb_now) begin
					fired.push_back(i + 1);
					if (tb_period[i] != 32'd0)
						tb_due[i] = tb_due[i] + tb_period[i];
					else
						tb_active[i] = 1'b0;
				end
			end
			for (int k = 0; k < fired.size(); k++)
				push_result(KIND_FIRE, fired[k], k == fired.size() - 1);
		end
		FUNC_ADD_ONCE, FUNC_ADD_PER: begin
			for (int i = NUM_SLOTS_DEF - 1; i >= 0; i--)
				if (!tb_active[i])
					slot = i;
			if (slot >= 0) begin
				tb_active[slot] = 1'b1;
				if (func == FUNC_ADD_ONCE) begin
					tb_period[slot] = 32'd0;
					tb_due[slot] = arg;
				end else begin
					tb_period[slot] = arg;
					tb_due[slot] = tb_now + arg;
				end
			end
			push_result(KIND_ADD, slot + 1, 1'b1);
		end
		default: begin
			if (arg >= 32'd1 && arg <= NUM_SLOTS_DEF) begin
				tb_active[arg - 1] = 1'b0;
				push_result(KIND_REMOVE, int'(arg), 1'b1);
			end else begin
				push_result(KIND_REMOVE, 0, 1'b1);
			end
		end
		endcase
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				run_timer_table(s_tuser, s_tdata);
			if (!s_tvalid || s_tready) begin
				if (src_gap == 0 && idle_on && $urandom_range(0, 7) == 0)
					src_gap = $urandom_range(1, 5);
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					next_req = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= next_req.func;
					s_tdata <= next_req.arg;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result sink backpressure
	always @(posedge clk) begin
		if (snk_gap == 0 && idle_on && $urandom_range(0, 7) == 0)
			snk_gap = $urandom_range(1, 5);
		if (snk_gap > 0) begin
			snk_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result kind %0d id %0d now %0d last %0d", $time,
					m_tuser, m_tdata[3:0], m_tdata[35:4], m_tlast);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (m_tuser !== want.kind || m_tdata[3:0] !== want.task_id ||
						m_tdata[35:4] !== want.now_us || m_tdata[39:36] !== 4'd0 ||
						m_tlast !== want.last) begin
					$display("%0t: expected kind %0d id %0d now %0d pad 0 last %0d", $time,
						want.kind, want.task_id, want.now_us, want.last);
					$display("%0t: actual   kind %0d id %0d now %0d pad %0h last %0d", $time,
						m_tuser, m_tdata[3:0], m_tdata[35:4], m_tdata[39:36], m_tlast);
					fail_count++;
				end
			end
		end
	end

	task automatic queue_request(input logic [1:0] func, input logic [31:0] arg);
		sched_request_t r;
		if (func == FUNC_TICK) begin
			gen_prescale = gen_prescale + 8'd1;
			if (gen_prescale >= ((gen_tpm == 8'd0) ? 8'd1 : gen_tpm)) begin
				gen_prescale = 8'd0;
				gen_now = gen_now + 32'd1;
			end
		end
		r.func = func;
		r.arg = arg;
		pending_requests.push_back(r);
	endtask

	task automatic queue_random_request();
		int pick;
		int sub;
		pick = $urandom_range(0, 99);
		sub = $urandom_range(0, 99);
		if (pick < 55) begin
			queue_request(FUNC_TICK, $urandom());
		end else if (pick < 70) begin
			if (sub < 70)
				queue_request(FUNC_ADD_ONCE, gen_now + $urandom_range(0, 12));
			else if (sub < 85)
				queue_request(FUNC_ADD_ONCE, $urandom());
			else
				queue_request(FUNC_ADD_ONCE, gen_now - $urandom_range(0, 5));
		end else if (pick < 82) begin
			if (sub < 60)
				queue_request(FUNC_ADD_PER, $urandom_range(1, 6));
			else if (sub < 70)
				queue_request(FUNC_ADD_PER, 32'd0);
			else if (sub < 85)
				queue_request(FUNC_ADD_PER, $urandom());
			else
				queue_request(FUNC_ADD_PER, 32'd0 - $urandom_range(1, 20));
		end else begin
			if (sub < 75)
				queue_request(FUNC_REMOVE, $urandom_range(1, NUM_SLOTS_DEF));
			else if (sub < 90)
				queue_request(FUNC_REMOVE, $urandom_range(0, 15));
			else
				queue_request(FUNC_REMOVE, $urandom());
		end
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_tick_rate(input logic [7:0] rate);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= rate;
		@(posedge clk);
		cfg_we <= 1'b0;
		tb_tpm = rate;
		gen_tpm = rate;
	endtask

	task automatic run_random(input int count);
		repeat (count) queue_random_request();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_request(FUNC_ADD_ONCE, 32'd0);
		queue_request(FUNC_TICK, 32'hFFFF_FFFF);
		queue_request(FUNC_REMOVE, 32'd0);
		queue_request(FUNC_REMOVE, 32'hFFFF_FFFF);
		queue_request(FUNC_REMOVE, 32'd5);
		// zero period behaves as one-shot due now
		queue_request(FUNC_ADD_PER, 32'd0);
		queue_request(FUNC_TICK, 32'd0);
		// fill the table, overflow it, then fire all slots at once
		repeat (NUM_SLOTS_DEF) queue_request(FUNC_ADD_ONCE, 32'd0);
		queue_request(FUNC_ADD_ONCE, 32'd0);
		queue_request(FUNC_ADD_PER, 32'd1);
		queue_request(FUNC_TICK, 32'd0);
		// far due time, quiet tick
		queue_request(FUNC_ADD_ONCE, 32'hFFFF_FFFF);
		queue_request(FUNC_TICK, 32'd0);
		queue_request(FUNC_REMOVE, 32'd1);
		// wrapped period keeps the slot behind the clock
		queue_request(FUNC_ADD_PER, 32'hFFFF_FFF0);
		repeat (3) queue_request(FUNC_TICK, 32'd0);
		queue_request(FUNC_REMOVE, 32'd1);
		queue_request(FUNC_ADD_PER, 32'd1);
		repeat (2) queue_request(FUNC_TICK, 32'd0);
		queue_request(FUNC_REMOVE, 32'd1);

		set_tick_rate(8'd0);
		run_random(90);
		set_tick_rate(8'd255);
		run_random(50);
		set_tick_rate(8'($urandom_range(2, 254)));
		run_random(90);
		set_tick_rate(8'd2);
		run_random(90);
		set_tick_rate(8'd1);
		idle_on = 1'b0;
		run_random(90);
		wait_idle();

		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
